FILE: sv/tcw_pkg.sv
package tcw_pkg;

    // screen geometry
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int TAB_WIDTH   = 8;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

    // field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int KIND_W = 2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // configuration register indexes
    localparam logic CFG_COLOR_ATTR    = 1'b0;
    localparam logic CFG_SCROLL_ENABLE = 1'b1;

    // character codes with special handling
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // power-up cell content and attribute
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    // cursor update for one put-character item
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              cell_we;
        logic [ADDR_W-1:0] cell_off;
        logic [CELL_W-1:0] cell_data;
        logic              scroll;
    } cur_upd_t;

    // linear screen offset of a row and column
    function automatic logic [ADDR_W-1:0] cell_offset(input logic [ROW_W-1:0] r,
                                                      input logic [COL_W-1:0] c);
        logic [ADDR_W-1:0] p;
        p = ADDR_W'(r) * ADDR_W'(SCREEN_COLS) + ADDR_W'(c);
        return p;
    endfunction

endpackage

FILE: sv/tcw_cursor.sv
module tcw_cursor (
    input  logic [tcw_pkg::CHAR_W-1:0] char_code,
    input  logic [tcw_pkg::COL_W-1:0]  col,
    input  logic [tcw_pkg::ROW_W-1:0]  row,
    input  logic [tcw_pkg::ATTR_W-1:0] attr,
    input  logic                       scroll_en,
    output tcw_pkg::cur_upd_t          upd
);

    // tab stops are a power of two apart, so the stop at or below the column is a mask
    localparam logic [tcw_pkg::COL_W:0] TAB_MASK = ~(tcw_pkg::COL_W+1)'(tcw_pkg::TAB_WIDTH - 1);

    logic [tcw_pkg::ROW_W:0]   row_w;
    logic [tcw_pkg::COL_W-1:0] col_w;
    logic [tcw_pkg::COL_W:0]   col_inc;
    logic [tcw_pkg::COL_W:0]   tab_col;
    logic [tcw_pkg::ROW_W-1:0] cell_row;
    logic [tcw_pkg::COL_W-1:0] cell_col;
    logic [tcw_pkg::CELL_W-1:0] cell_data;
    logic                      cell_we;
    logic                      scroll;

    // next column candidates
    assign col_inc = {1'b0, col} + 1'b1;
    assign tab_col = ({1'b0, col} & TAB_MASK) + (tcw_pkg::COL_W+1)'(tcw_pkg::TAB_WIDTH);

    // character decode and cursor motion
    always_comb begin
        col_w     = col;
        row_w     = {1'b0, row};
        cell_we   = 1'b0;
        cell_row  = row;
        cell_col  = col;
        cell_data = {attr, char_code};
        scroll    = 1'b0;
        case (char_code)
            tcw_pkg::CH_NEWLINE: begin
                col_w = '0;
                row_w = row_w + 1'b1;
            end
            tcw_pkg::CH_RETURN: begin
                col_w = '0;
            end
            tcw_pkg::CH_BACKSPACE: begin
                if (col != '0) begin
                    col_w = col - 1'b1;
                end else if (row != '0) begin
                    row_w = {1'b0, row} - 1'b1;
                    col_w = tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS - 1);
                end
                cell_we   = 1'b1;
                cell_row  = row_w[tcw_pkg::ROW_W-1:0];
                cell_col  = col_w;
                cell_data = {attr, tcw_pkg::CH_SPACE};
            end
            tcw_pkg::CH_TAB: begin
                if (tab_col >= (tcw_pkg::COL_W+1)'(tcw_pkg::SCREEN_COLS)) begin
                    col_w = '0;
                    row_w = row_w + 1'b1;
                end else begin
                    col_w = tab_col[tcw_pkg::COL_W-1:0];
                end
            end
            default: begin
                cell_we = 1'b1;
                if (col_inc >= (tcw_pkg::COL_W+1)'(tcw_pkg::SCREEN_COLS)) begin
                    col_w = '0;
                    row_w = row_w + 1'b1;
                end else begin
                    col_w = col_inc[tcw_pkg::COL_W-1:0];
                end
            end
        endcase
        // past the last row: scroll or pin to the last row
        if (row_w >= (tcw_pkg::ROW_W+1)'(tcw_pkg::SCREEN_ROWS)) begin
            row_w = (tcw_pkg::ROW_W+1)'(tcw_pkg::SCREEN_ROWS - 1);
            if (scroll_en) begin
                scroll = 1'b1;
            end else begin
                col_w = '0;
            end
        end
    end

    assign upd.col       = col_w;
    assign upd.row       = row_w[tcw_pkg::ROW_W-1:0];
    assign upd.cell_we   = cell_we;
    assign upd.cell_off  = tcw_pkg::cell_offset(cell_row, cell_col);
    assign upd.cell_data = cell_data;
    assign upd.scroll    = scroll;

endmodule

FILE: sv/text_console_writer_core.sv
// Text console writer: an 80x25 screen of 16-bit cells (character low byte,
// attribute high byte) held in one synchronous RAM, plus a cursor. The screen
// is kept as a ring of rows with a top-row base offset, so a scroll rotates the
// base and blanks only the recycled row. Put character, read cell and the
// unused kind register their result in the result state once the output
// register is free, and s_ready comes back as that result is registered, so
// such an item is finished before the next is taken; a put character that
// scrolls first blanks one row in the fill state, and clear screen first
// blanks every cell there, both through the single RAM write port, one cell
// per cycle. After reset the block fills the RAM with 0x0720 with s_ready low;
// configuration writes are taken throughout. One item is worked on at a time,
// and the next item is taken while a result waits on the m_ side.
module text_console_writer_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tcw_pkg::KIND_W-1:0]  s_kind,
    input  logic [tcw_pkg::CHAR_W-1:0]  s_char_code,
    input  logic [tcw_pkg::ADDR_W-1:0]  s_cell_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tcw_pkg::CELL_W-1:0]  m_cell_data,
    output logic [tcw_pkg::COL_W-1:0]   m_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]   m_cursor_row,
    output logic [tcw_pkg::ADDR_W-1:0]  m_cursor_offset
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILL = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [tcw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [tcw_pkg::ATTR_W-1:0] attr_reg, attr_next;
    logic                       scroll_en_reg, scroll_en_next;
    logic [tcw_pkg::ADDR_W-1:0] base_off_reg, base_off_next;
    logic [tcw_pkg::ADDR_W-1:0] fill_addr_reg, fill_addr_next;
    logic [tcw_pkg::ADDR_W-1:0] fill_end_reg, fill_end_next;
    logic [tcw_pkg::CELL_W-1:0] fill_val_reg, fill_val_next;
    logic                       pend_reg, pend_next;
    logic                       read_ok_reg, read_ok_next;
    logic                       m_valid_reg, m_valid_next;
    logic [tcw_pkg::CELL_W-1:0] m_data_reg, m_data_next;
    logic [tcw_pkg::COL_W-1:0]  m_col_reg, m_col_next;
    logic [tcw_pkg::ROW_W-1:0]  m_row_reg, m_row_next;
    logic [tcw_pkg::ADDR_W-1:0] m_off_reg, m_off_next;

    logic [tcw_pkg::CELL_W-1:0] screen_mem [tcw_pkg::CELL_COUNT];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;
    logic                       mem_we;
    logic [tcw_pkg::ADDR_W-1:0] mem_wa;
    logic [tcw_pkg::CELL_W-1:0] mem_wd;
    logic                       rd_en;
    logic [tcw_pkg::ADDR_W-1:0] rd_addr;
    logic [tcw_pkg::ADDR_W-1:0] base_plus_row;
    logic [tcw_pkg::CELL_W-1:0] blank;
    logic                       idx_ok;
    tcw_pkg::cur_upd_t          upd;

    // logical screen offset to ram address through the ring base
    function automatic logic [tcw_pkg::ADDR_W-1:0] phys_addr(
        input logic [tcw_pkg::ADDR_W-1:0] off,
        input logic [tcw_pkg::ADDR_W-1:0] base
    );
        logic [tcw_pkg::ADDR_W:0] s;
        s = {1'b0, off} + {1'b0, base};
        if (s >= (tcw_pkg::ADDR_W+1)'(tcw_pkg::CELL_COUNT)) begin
            s = s - (tcw_pkg::ADDR_W+1)'(tcw_pkg::CELL_COUNT);
        end
        return s[tcw_pkg::ADDR_W-1:0];
    endfunction

    tcw_cursor u_cursor (
        .char_code (s_char_code),
        .col       (col_reg),
        .row       (row_reg),
        .attr      (attr_reg),
        .scroll_en (scroll_en_reg),
        .upd       (upd)
    );

    assign blank  = {attr_reg, tcw_pkg::CH_SPACE};
    assign idx_ok = (s_cell_index < tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT));

    // base moves down one row on a scroll, wrapping at the screen end
    always_comb begin
        base_plus_row = base_off_reg + tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_COLS);
        if (base_plus_row == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT)) begin
            base_plus_row = '0;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // control and datapath next state
    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        attr_next      = attr_reg;
        scroll_en_next = scroll_en_reg;
        base_off_next  = base_off_reg;
        fill_addr_next = fill_addr_reg;
        fill_end_next  = fill_end_reg;
        fill_val_next  = fill_val_reg;
        pend_next      = pend_reg;
        read_ok_next   = read_ok_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_col_next     = m_col_reg;
        m_row_next     = m_row_reg;
        m_off_next     = m_off_reg;
        mem_we         = 1'b0;
        mem_wa         = phys_addr(upd.cell_off, base_off_reg);
        mem_wd         = upd.cell_data;
        rd_en          = 1'b0;
        rd_addr        = phys_addr(s_cell_index, base_off_reg);

        // configuration writes
        if (cfg_we) begin
            case (cfg_index)
                tcw_pkg::CFG_COLOR_ATTR:    attr_next      = cfg_data;
                tcw_pkg::CFG_SCROLL_ENABLE: scroll_en_next = cfg_data[0];
                default:                    attr_next      = attr_reg;
            endcase
        end

        // output register drains
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    read_ok_next = 1'b0;
                    state_next   = ST_RESP;
                    case (s_kind)
                        tcw_pkg::KIND_PUT: begin
                            mem_we   = upd.cell_we;
                            col_next = upd.col;
                            row_next = upd.row;
                            if (upd.scroll) begin
                                base_off_next  = base_plus_row;
                                fill_addr_next = base_off_reg;
                                fill_end_next  = base_off_reg
                                                 + tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_COLS - 1);
                                fill_val_next  = blank;
                                pend_next      = 1'b1;
                                state_next     = ST_FILL;
                            end
                        end
                        tcw_pkg::KIND_CLEAR: begin
                            base_off_next  = '0;
                            col_next       = '0;
                            row_next       = '0;
                            fill_addr_next = '0;
                            fill_end_next  = tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
                            fill_val_next  = blank;
                            pend_next      = 1'b1;
                            state_next     = ST_FILL;
                        end
                        tcw_pkg::KIND_READ: begin
                            rd_en        = idx_ok;
                            read_ok_next = idx_ok;
                        end
                        default: begin
                            read_ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                // one cell per cycle over the fill range
                mem_we         = 1'b1;
                mem_wa         = fill_addr_reg;
                mem_wd         = fill_val_reg;
                fill_addr_next = fill_addr_reg + 1'b1;
                if (fill_addr_reg == fill_end_reg) begin
                    state_next = pend_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = read_ok_reg ? rd_data_reg : '0;
                    m_col_next   = col_reg;
                    m_row_next   = row_reg;
                    m_off_next   = tcw_pkg::cell_offset(row_reg, col_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= tcw_pkg::RESET_ATTR;
            scroll_en_reg <= 1'b1;
            base_off_reg  <= '0;
            fill_addr_reg <= '0;
            fill_end_reg  <= tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
            fill_val_reg  <= tcw_pkg::RESET_CELL;
            pend_reg      <= 1'b0;
            read_ok_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            attr_reg      <= attr_next;
            scroll_en_reg <= scroll_en_next;
            base_off_reg  <= base_off_next;
            fill_addr_reg <= fill_addr_next;
            fill_end_reg  <= fill_end_next;
            fill_val_reg  <= fill_val_next;
            pend_reg      <= pend_next;
            read_ok_reg   <= read_ok_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_col_reg  <= m_col_next;
        m_row_reg  <= m_row_next;
        m_off_reg  <= m_off_next;
    end

    // screen ram, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rd_data_reg <= screen_mem[rd_addr];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cell_data     = m_data_reg;
    assign m_cursor_col    = m_col_reg;
    assign m_cursor_row    = m_row_reg;
    assign m_cursor_offset = m_off_reg;

`ifndef SYNTHESIS
    // cursor never leaves the screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg < tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS))
        && (row_reg < tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS)))
        else $error("cursor out of range");

    // ram writes and reads stay inside the screen
    a_ram_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we |-> (mem_wa < tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT)))
        and (rd_en |-> (rd_addr < tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT))))
        else $error("ram access out of range");

    // an accepted item reaches the result stage or a fill the next cycle
    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> ((state_reg == ST_RESP) || (state_reg == ST_FILL)))
        else $error("accepted item lost");
`endif

endmodule
